// ----- sv/arp_cache_and_responder_top_defines.svh -----
`ifndef ARP_CACHE_AND_RESPONDER_TOP_DEFINES_SVH
`define ARP_CACHE_AND_RESPONDER_TOP_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define ARPC_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define ARPC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- sv/arpc_pkg.sv -----
`default_nettype none

package arpc_pkg;

    localparam int ENTRIES = 16;
    localparam int IDX_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int CNT_W   = $clog2(ENTRIES + 1);

    localparam int IP_W     = 32;
    localparam int MAC_W    = 48;
    localparam int OP_W     = 16;
    localparam int ACT_W    = 3;

    // input word: lookup_ip, opcode, src_ip, src_mac, dst_ip
    localparam int IN_TDATA_W  = IP_W + OP_W + IP_W + MAC_W + IP_W;
    // result word: result_mac, result_ip
    localparam int OUT_TDATA_W = MAC_W + IP_W;

    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;
    localparam logic REG_IDX_OWN_IP = 1'b0;

    localparam logic [OP_W-1:0] OP_REQUEST = 16'd1;
    localparam logic [OP_W-1:0] OP_REPLY   = 16'd2;

    typedef enum logic [ACT_W-1:0] {
        ACT_NONE    = 3'd0,
        ACT_HIT     = 3'd1,
        ACT_REQ     = 3'd2,
        ACT_REPLY   = 3'd3,
        ACT_STORED  = 3'd4,
        ACT_DROPPED = 3'd5
    } t_action;

    typedef enum logic [1:0] {
        S_IDLE,
        S_DECODE,
        S_SCAN,
        S_OUT
    } t_state;

    typedef struct packed {
        logic    load;
        logic    scan_start;
        logic    step;
        logic    set_res;
        t_action res_act;
        logic    append;
        logic    push;
    } t_dp_cmd;

    typedef struct packed {
        logic             kind;
        logic             op_req;
        logic             op_rep;
        logic             own_hit;
        logic             full;
        logic             match;
        logic             more;
        logic             out_free;
        logic [CNT_W-1:0] cnt;
    } t_dp_stat;

endpackage

`default_nettype wire

// ----- sv/arpc_ctrl.sv -----
`default_nettype none

module arpc_ctrl
    import arpc_pkg::*;
(
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     i_s_tvalid,
    output logic          o_s_tready,
    input  wire t_dp_stat i_stat,
    output t_dp_cmd       o_cmd
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_s_tready = 1'b0;
        o_cmd      = '0;
        o_cmd.res_act = ACT_NONE;
        unique case (r_state)
            S_IDLE: begin
                o_s_tready = 1'b1;
                if (i_s_tvalid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_DECODE;
                end
            end
            S_DECODE: begin
                if (!i_stat.kind) begin
                    o_cmd.scan_start = 1'b1;
                    n_state          = S_SCAN;
                end else begin
                    o_cmd.set_res = 1'b1;
                    n_state       = S_OUT;
                    if (i_stat.op_req) begin
                        o_cmd.res_act = i_stat.own_hit ? ACT_REPLY : ACT_NONE;
                    end else if (i_stat.op_rep) begin
                        if (i_stat.full) begin
                            o_cmd.res_act = ACT_DROPPED;
                        end else begin
                            o_cmd.append  = 1'b1;
                            o_cmd.res_act = ACT_STORED;
                        end
                    end
                end
            end
            S_SCAN: begin
                // compare the entry read last cycle while fetching the next one
                if (i_stat.match) begin
                    o_cmd.set_res = 1'b1;
                    o_cmd.res_act = ACT_HIT;
                    n_state       = S_OUT;
                end else if (i_stat.more) begin
                    o_cmd.step = 1'b1;
                end else begin
                    o_cmd.set_res = 1'b1;
                    o_cmd.res_act = ACT_REQ;
                    n_state       = S_OUT;
                end
            end
            S_OUT: begin
                if (i_stat.out_free) begin
                    o_cmd.push = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

// ----- sv/arpc_datapath.sv -----
`default_nettype none

module arpc_datapath
    import arpc_pkg::*;
(
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    input  wire t_dp_cmd                 i_cmd,
    output t_dp_stat                     o_stat,
    // lookup_ip, opcode, src_ip, src_mac, dst_ip (from bit 0 up)
    input  wire logic [IN_TDATA_W-1:0]   i_tdata,
    // kind
    input  wire logic                    i_tuser,
    input  wire logic                    i_cfg_we,
    input  wire logic [IP_W-1:0]         i_cfg_data,
    output logic [IP_W-1:0]              o_own_ip,
    input  wire logic                    i_m_tready,
    output logic                         o_m_tvalid,
    // result_mac, result_ip (from bit 0 up)
    output logic [OUT_TDATA_W-1:0]       o_m_tdata,
    // action
    output logic [ACT_W-1:0]             o_m_tuser
);

    logic [IP_W-1:0]  r_own_ip;

    logic             r_kind;
    logic [IP_W-1:0]  r_lip;
    logic [OP_W-1:0]  r_op;
    logic [IP_W-1:0]  r_sip;
    logic [MAC_W-1:0] r_smac;
    logic [IP_W-1:0]  r_tip;

    logic [IP_W-1:0]  mem_ip  [ENTRIES];
    logic [MAC_W-1:0] mem_mac [ENTRIES];
    logic [IP_W-1:0]  r_rd_ip;
    logic [MAC_W-1:0] r_rd_mac;
    logic [CNT_W-1:0] r_rd_idx;
    logic             r_cmp_valid;
    logic [CNT_W-1:0] r_count;

    t_action          r_res_act;
    logic [MAC_W-1:0] r_res_mac;
    logic [IP_W-1:0]  r_res_ip;
    logic [MAC_W-1:0] n_res_mac;
    logic [IP_W-1:0]  n_res_ip;

    logic             r_out_valid;
    logic [ACT_W-1:0] r_out_act;
    logic [MAC_W-1:0] r_out_mac;
    logic [IP_W-1:0]  r_out_ip;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_own_ip <= '0;
        end else if (i_cfg_we) begin
            r_own_ip <= i_cfg_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_kind <= i_tuser;
            r_lip  <= i_tdata[IP_W-1:0];
            r_op   <= i_tdata[IP_W +: OP_W];
            r_sip  <= i_tdata[IP_W+OP_W +: IP_W];
            r_smac <= i_tdata[2*IP_W+OP_W +: MAC_W];
            r_tip  <= i_tdata[2*IP_W+OP_W+MAC_W +: IP_W];
        end
    end

    // table memory: append-only write, one registered read per cycle
    always_ff @(posedge i_clk) begin
        if (i_cmd.append) begin
            mem_ip[r_count[IDX_W-1:0]]  <= r_sip;
            mem_mac[r_count[IDX_W-1:0]] <= r_smac;
        end
        if (i_cmd.step) begin
            r_rd_ip  <= mem_ip[r_rd_idx[IDX_W-1:0]];
            r_rd_mac <= mem_mac[r_rd_idx[IDX_W-1:0]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_rd_idx    <= '0;
            r_cmp_valid <= 1'b0;
        end else begin
            if (i_cmd.append) begin
                r_count <= r_count + CNT_W'(1);
            end
            if (i_cmd.scan_start) begin
                r_rd_idx <= '0;
            end else if (i_cmd.step) begin
                r_rd_idx <= r_rd_idx + CNT_W'(1);
            end
            r_cmp_valid <= i_cmd.step;
        end
    end

    always_comb begin
        n_res_mac = '0;
        n_res_ip  = '0;
        case (i_cmd.res_act)
            ACT_HIT: begin
                n_res_mac = r_rd_mac;
            end
            ACT_REQ: begin
                n_res_ip = r_lip;
            end
            ACT_REPLY: begin
                n_res_mac = r_smac;
                n_res_ip  = r_sip;
            end
            default: begin
                n_res_mac = '0;
                n_res_ip  = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.set_res) begin
            r_res_act <= i_cmd.res_act;
            r_res_mac <= n_res_mac;
            r_res_ip  <= n_res_ip;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.push) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.push) begin
            r_out_act <= r_res_act;
            r_out_mac <= r_res_mac;
            r_out_ip  <= r_res_ip;
        end
    end

    always_comb begin
        o_stat          = '0;
        o_stat.kind     = r_kind;
        o_stat.op_req   = (r_op == OP_REQUEST);
        o_stat.op_rep   = (r_op == OP_REPLY);
        o_stat.own_hit  = (r_tip == r_own_ip);
        o_stat.full     = (r_count == CNT_W'(ENTRIES));
        o_stat.match    = r_cmp_valid && (r_rd_ip == r_lip);
        o_stat.more     = (r_rd_idx < r_count);
        o_stat.out_free = !r_out_valid || i_m_tready;
        o_stat.cnt      = r_count;
    end

    assign o_own_ip   = r_own_ip;
    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {r_out_ip, r_out_mac};
    assign o_m_tuser  = r_out_act;

endmodule

`default_nettype wire

// ----- sv/arp_cache_and_responder_top.sv -----
// Sequence: a packet word is decoded, its result registered, then pushed to the
//   output register; a lookup reads one table entry per cycle up to a hit or the end.
// Flow: one word at a time; a new word is taken once the previous one has
//   reached the output register; the push waits while that register is held.
// Reset (synchronous, active low): table empty, own_ip zero, no result pending.
`default_nettype none
`include "arp_cache_and_responder_top_defines.svh"

module arp_cache_and_responder_top
    import arpc_pkg::*;
(
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    input  wire logic                    s_axis_tvalid,
    output logic                         s_axis_tready,
    // lookup_ip, opcode, src_ip, src_mac, dst_ip (from bit 0 up)
    input  wire logic [IN_TDATA_W-1:0]   s_axis_tdata,
    // kind
    input  wire logic                    s_axis_tuser,
    output logic                         m_axis_tvalid,
    input  wire logic                    m_axis_tready,
    // result_mac, result_ip (from bit 0 up)
    output logic [OUT_TDATA_W-1:0]       m_axis_tdata,
    // action
    output logic [ACT_W-1:0]             m_axis_tuser,
    input  wire logic                    psel,
    input  wire logic                    penable,
    input  wire logic                    pwrite,
    input  wire logic [APB_ADDR_W-1:0]   paddr,
    input  wire logic [APB_DATA_W-1:0]   pwdata,
    output logic [APB_DATA_W-1:0]        prdata,
    output logic                         pready
);

    t_dp_cmd         cmd;
    t_dp_stat        stat;
    logic            cfg_we;
    logic [IP_W-1:0] own_ip;

    assign pready = 1'b1;
    assign cfg_we = psel && penable && pwrite && pready
                    && (paddr[APB_ADDR_W-1] == REG_IDX_OWN_IP);
    assign prdata = (paddr[APB_ADDR_W-1] == REG_IDX_OWN_IP) ? own_ip : '0;

    arpc_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (s_axis_tvalid),
        .o_s_tready (s_axis_tready),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    arpc_datapath u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (cmd),
        .o_stat     (stat),
        .i_tdata    (s_axis_tdata),
        .i_tuser    (s_axis_tuser),
        .i_cfg_we   (cfg_we),
        .i_cfg_data (pwdata),
        .o_own_ip   (own_ip),
        .i_m_tready (m_axis_tready),
        .o_m_tvalid (m_axis_tvalid),
        .o_m_tdata  (m_axis_tdata),
        .o_m_tuser  (m_axis_tuser)
    );

    `ARPC_ASSERT_NEXT(a_one_word_in_flight, i_clk, i_rst_n, s_axis_tvalid && s_axis_tready, !s_axis_tready, "new word accepted while one is in flight")
    `ARPC_ASSERT_NOW(a_count_bounded, i_clk, i_rst_n, 1'b1, stat.cnt <= CNT_W'(ENTRIES), "entry count exceeds table size")
    `ARPC_ASSERT_NOW(a_hit_has_no_ip, i_clk, i_rst_n, m_axis_tvalid && (m_axis_tuser == ACT_HIT), m_axis_tdata[OUT_TDATA_W-1:MAC_W] == '0, "hit result carries an ip")
    `ARPC_ASSERT_NOW(a_append_has_room, i_clk, i_rst_n, cmd.append, !stat.full, "append into a full table")

endmodule

`default_nettype wire

// ----- tb/testbench.sv -----
`default_nettype none

module testbench;
    import arpc_pkg::*;

    localparam int RAND_PER_PHASE = 500;
    localparam int HOLD_CYCLES    = 300;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int DRAIN_CYCLES   = ENTRIES + 8;
    localparam logic [APB_ADDR_W-1:0] ADDR_OWN_IP = {REG_IDX_OWN_IP, 2'b00};

    typedef struct packed {
        logic             kind;
        logic [IP_W-1:0]  lookup_ip;
        logic [OP_W-1:0]  opcode;
        logic [IP_W-1:0]  src_ip;
        logic [MAC_W-1:0] src_mac;
        logic [IP_W-1:0]  dst_ip;
    } t_arp_item;

    typedef struct packed {
        t_action          act;
        logic [MAC_W-1:0] mac;
        logic [IP_W-1:0]  ip;
    } t_arp_res;

    typedef struct packed {
        t_arp_item it;
        logic      typed;
        t_arp_res  res;
    } t_dir_row;

    localparam logic [IP_W-1:0]  MY_IP   = 32'hC0A8_0001;
    localparam logic [IP_W-1:0]  IP_ONES = 32'hFFFF_FFFF;
    localparam logic [MAC_W-1:0] MAC_ONES = 48'hFFFF_FFFF_FFFF;
    localparam logic [MAC_W-1:0] MAC_A   = 48'h0211_2233_4455;
    localparam logic [MAC_W-1:0] MAC_B   = 48'h0266_7788_99AA;
    localparam int DIR_N = 21;

    // own_ip is MY_IP while these rows run
    t_dir_row dir_rows [DIR_N] = '{
        '{'{1'b0, 32'hC0A8_0002, 16'h0, 32'h0, 48'h0, 32'h0}, 1'b1,
          '{ACT_REQ, 48'h0, 32'hC0A8_0002}},
        '{'{1'b0, 32'h0, 16'h0, 32'h0, 48'h0, 32'h0}, 1'b1,
          '{ACT_REQ, 48'h0, 32'h0}},
        '{'{1'b0, IP_ONES, 16'hFFFF, IP_ONES, MAC_ONES, IP_ONES}, 1'b1,
          '{ACT_REQ, 48'h0, IP_ONES}},
        '{'{1'b1, 32'h0, OP_REQUEST, IP_ONES, MAC_ONES, MY_IP}, 1'b1,
          '{ACT_REPLY, MAC_ONES, IP_ONES}},
        '{'{1'b1, 32'h0, OP_REQUEST, 32'h0A00_0009, MAC_A, 32'hC0A8_0002}, 1'b1,
          '{ACT_NONE, 48'h0, 32'h0}},
        '{'{1'b1, IP_ONES, OP_REQUEST, 32'h0, 48'h0, MY_IP}, 1'b1,
          '{ACT_REPLY, 48'h0, 32'h0}},
        '{'{1'b1, 32'h0, 16'h0, 32'h0A00_0001, MAC_A, MY_IP}, 1'b1,
          '{ACT_NONE, 48'h0, 32'h0}},
        '{'{1'b1, 32'h0, 16'hFFFF, 32'h0A00_0001, MAC_A, MY_IP}, 1'b1,
          '{ACT_NONE, 48'h0, 32'h0}},
        '{'{1'b1, 32'h0, 16'h3, 32'h0A00_0001, MAC_A, MY_IP}, 1'b1,
          '{ACT_NONE, 48'h0, 32'h0}},
        '{'{1'b1, 32'h0, OP_REPLY, 32'h0A00_0001, MAC_A, MY_IP}, 1'b1,
          '{ACT_STORED, 48'h0, 32'h0}},
        '{'{1'b0, 32'h0A00_0001, 16'h0, 32'h0, 48'h0, 32'h0}, 1'b1,
          '{ACT_HIT, MAC_A, 32'h0}},
        // duplicate address: stored again, lookups keep the first one
        '{'{1'b1, 32'h0, OP_REPLY, 32'h0A00_0001, MAC_B, 32'h0}, 1'b1,
          '{ACT_STORED, 48'h0, 32'h0}},
        '{'{1'b0, 32'h0A00_0001, 16'h0, 32'h0, 48'h0, 32'h0}, 1'b1,
          '{ACT_HIT, MAC_A, 32'h0}},
        '{'{1'b0, 32'h0A00_0002, OP_REPLY, 32'h0A00_0002, MAC_B, MY_IP}, 1'b1,
          '{ACT_REQ, 48'h0, 32'h0A00_0002}},
        '{'{1'b1, 32'h0A00_0001, OP_REPLY, 32'h0A00_0002, 48'h0, 32'h0}, 1'b0,
          '{ACT_NONE, 48'h0, 32'h0}},
        '{'{1'b1, 32'h0, OP_REPLY, 32'h0, 48'h0, 32'h0}, 1'b0,
          '{ACT_NONE, 48'h0, 32'h0}},
        '{'{1'b1, IP_ONES, OP_REPLY, IP_ONES, MAC_ONES, IP_ONES}, 1'b0,
          '{ACT_NONE, 48'h0, 32'h0}},
        '{'{1'b0, 32'h0, 16'h0, 32'h0, 48'h0, 32'h0}, 1'b0,
          '{ACT_NONE, 48'h0, 32'h0}},
        '{'{1'b0, IP_ONES, 16'h0, 32'h0, 48'h0, 32'h0}, 1'b0,
          '{ACT_NONE, 48'h0, 32'h0}},
        '{'{1'b0, 32'h0A00_0002, 16'h0, 32'h0, 48'h0, 32'h0}, 1'b0,
          '{ACT_NONE, 48'h0, 32'h0}},
        '{'{1'b1, MY_IP, OP_REQUEST, 32'h0A00_0003, MAC_B, MY_IP}, 1'b0,
          '{ACT_NONE, 48'h0, 32'h0}}
    };

    logic                   i_clk;
    logic                   i_rst_n;
    logic                   s_axis_tvalid;
    logic                   s_axis_tready;
    logic [IN_TDATA_W-1:0]  s_axis_tdata;
    logic                   s_axis_tuser;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready;
    logic [OUT_TDATA_W-1:0] m_axis_tdata;
    logic [ACT_W-1:0]       m_axis_tuser;
    logic                   psel;
    logic                   penable;
    logic                   pwrite;
    logic [APB_ADDR_W-1:0]  paddr;
    logic [APB_DATA_W-1:0]  pwdata;
    logic [APB_DATA_W-1:0]  prdata;
    logic                   pready;

    arp_cache_and_responder_top dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    // shadow of the block's table and register
    logic [IP_W-1:0]  cache_ip  [ENTRIES];
    logic [MAC_W-1:0] cache_mac [ENTRIES];
    int               cache_fill;
    logic [IP_W-1:0]  station_ip;

    t_arp_res arp_results_due [$];
    int       mismatches;
    int       src_idle_pct;
    int       dst_idle_pct;
    int       hold_asked;
    int       hold_served;

    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    function automatic t_arp_res resolve_arp(input t_arp_item it);
        t_arp_res r;
        int       i;
        r = '{ACT_NONE, '0, '0};
        if (it.kind == 1'b0) begin
            r = '{ACT_REQ, '0, it.lookup_ip};
            // walk down so the lowest matching entry wins
            for (i = cache_fill - 1; i >= 0; i--) begin
                if (cache_ip[i] == it.lookup_ip) r = '{ACT_HIT, cache_mac[i], '0};
            end
        end else if (it.opcode == OP_REQUEST) begin
            if (it.dst_ip == station_ip) r = '{ACT_REPLY, it.src_mac, it.src_ip};
        end else if (it.opcode == OP_REPLY) begin
            if (cache_fill < ENTRIES) begin
                cache_ip[cache_fill]  = it.src_ip;
                cache_mac[cache_fill] = it.src_mac;
                cache_fill++;
                r.act = ACT_STORED;
            end else begin
                r.act = ACT_DROPPED;
            end
        end
        return r;
    endfunction

    // mix: below 40 lookup, below 75 request, below 90 reply, else random opcode
    function automatic t_arp_item rand_arp_item(input int mix);
        t_arp_item it;
        it.kind      = 1'b1;
        it.lookup_ip = $urandom;
        it.opcode    = 16'($urandom_range(65535));
        it.src_ip    = $urandom;
        it.src_mac   = {16'($urandom), 32'($urandom)};
        it.dst_ip    = $urandom;
        if (mix < 40) begin
            it.kind = 1'b0;
            if (cache_fill > 0 && $urandom_range(99) < 70)
                it.lookup_ip = cache_ip[$urandom_range(cache_fill - 1)];
        end else if (mix < 75) begin
            it.opcode = OP_REQUEST;
            if ($urandom_range(1) == 1) it.dst_ip = station_ip;
        end else if (mix < 90) begin
            it.opcode = OP_REPLY;
        end
        return it;
    endfunction

    // enter and leave at a falling edge
    task automatic push_word(input t_arp_item it, input logic typed, input t_arp_res typed_res);
        t_arp_res r;
        while ($urandom_range(99) < src_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= it.kind;
        s_axis_tdata  <= {it.dst_ip, it.src_mac, it.src_ip, it.opcode, it.lookup_ip};
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        r = resolve_arp(it);
        arp_results_due.push_back(typed ? typed_res : r);
        @(negedge i_clk);
    endtask

    // drop the last word, then wait for every result
    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        while (arp_results_due.size() != 0) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    // write own_ip, then read it back
    task automatic set_own_ip(input logic [IP_W-1:0] value);
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ADDR_OWN_IP;
        pwdata  <= value;
        @(negedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        station_ip = value;
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(negedge i_clk);
        psel    <= 1'b1;
        pwrite  <= 1'b0;
        @(negedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        if (prdata != station_ip) begin
            $display("%0t: own_ip readback expected %h got %h", $time, station_ip, prdata);
            mismatches++;
        end
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    always @(posedge i_clk) begin
        t_arp_res got;
        t_arp_res want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got = '{t_action'(m_axis_tuser), m_axis_tdata[MAC_W-1:0], m_axis_tdata[MAC_W +: IP_W]};
            if (arp_results_due.size() == 0) begin
                $display("%0t: unexpected result action %0d mac %h ip %h",
                         $time, got.act, got.mac, got.ip);
                mismatches++;
            end else begin
                want = arp_results_due.pop_front();
                if (got.act != want.act) begin
                    $display("%0t: action expected %0d got %0d", $time, want.act, got.act);
                    mismatches++;
                end
                if (got.mac != want.mac) begin
                    $display("%0t: result_mac expected %h got %h", $time, want.mac, got.mac);
                    mismatches++;
                end
                if (got.ip != want.ip) begin
                    $display("%0t: result_ip expected %h got %h", $time, want.ip, got.ip);
                    mismatches++;
                end
            end
        end
    end

    initial begin
        m_axis_tready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_asked != hold_served) begin
                // long back-pressure so the input side fills and stalls
                m_axis_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge i_clk);
                hold_served++;
            end else begin
                m_axis_tready <= ($urandom_range(99) >= dst_idle_pct);
            end
        end
    end

    initial begin
        int quiet;
        quiet = 0;
        while (quiet < WATCHDOG_LIMIT) begin
            @(posedge i_clk);
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
                quiet = 0;
            else
                quiet++;
        end
        $display("TB_ERROR");
        $finish;
    end

    initial begin
        int ph;
        int n;
        i_rst_n       = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = 1'b0;
        psel          = 1'b0;
        penable       = 1'b0;
        pwrite        = 1'b0;
        paddr         = '0;
        pwdata        = '0;
        mismatches    = 0;
        hold_asked    = 0;
        hold_served   = 0;
        cache_fill    = 0;
        station_ip    = '0;
        src_idle_pct  = 33;
        dst_idle_pct  = 71;
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        set_own_ip(MY_IP);
        for (n = 0; n < DIR_N; n++) push_word(dir_rows[n].it, dir_rows[n].typed, dir_rows[n].res);

        // fill the table, then overflow it twice
        while (cache_fill < ENTRIES) push_word(rand_arp_item(80), 1'b0, '0);
        repeat (2) push_word(rand_arp_item(80), 1'b0, '0);

        for (ph = 0; ph < 3; ph++) begin
            src_idle_pct = (ph == 0) ? 33 : (ph == 1) ? 71 : 0;
            dst_idle_pct = (ph == 0) ? 71 : (ph == 1) ? 33 : 0;
            wait_drained();
            set_own_ip((ph == 0) ? 32'h0 : (ph == 1) ? IP_ONES : 32'($urandom));
            if (ph == 0) hold_asked++;
            for (n = 0; n < RAND_PER_PHASE; n++) begin
                if (ph == 1 && n == RAND_PER_PHASE / 2) wait_drained();
                push_word(rand_arp_item($urandom_range(99)), 1'b0, '0);
            end
        end

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (arp_results_due.size() != 0) begin
            $display("%0t: %0d results never arrived", $time, arp_results_due.size());
            mismatches++;
        end
        if (mismatches == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

`default_nettype wire

// ----- filelist.f -----
+incdir+sv
sv/arpc_pkg.sv
sv/arpc_ctrl.sv
sv/arpc_datapath.sv
sv/arp_cache_and_responder_top.sv
tb/testbench.sv
